FILE: rtl/core/gkde_pkg.sv
package gkde_pkg;

    // default sizes
    localparam int MAX_POINTS_DEF = 1024;
    localparam int MAX_DIMS_DEF   = 4;

    localparam int COORD_W  = 16;
    localparam int IBW_W    = 16;
    localparam int NORM_W   = 32;
    localparam int DENS_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int NUM_BW   = 4;
    localparam int SQ_W     = 34;
    localparam int KBITS    = 21;
    localparam int K_W      = 33;

    // request function codes
    typedef enum logic [1:0] {
        FN_CLEAR = 2'd0,
        FN_LOAD  = 2'd1,
        FN_QUERY = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMS  = 3'd0,
        CFG_IBW0  = 3'd1,
        CFG_IBW1  = 3'd2,
        CFG_IBW2  = 3'd3,
        CFG_IBW3  = 3'd4,
        CFG_NORM  = 3'd5,
        CFG_RSV6  = 3'd6,
        CFG_RSV7  = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_ROUND,
        S_WALK,
        S_DRAIN,
        S_MUL,
        S_ADD,
        S_OUT
    } t_state;

    // control from the sequencer to one lane
    typedef struct packed {
        logic scale_en;
        logic dim_used;
    } t_lane_ctl;

    // exp(-2^(b-16)) in unsigned Q0.32 for each bit of the half distance
    function automatic logic [31:0] exp_bit(input int b);
        logic [31:0] c;
        begin
            case (b)
                0:  c = 32'd4294901760;
                1:  c = 32'd4294836226;
                2:  c = 32'd4294705160;
                3:  c = 32'd4294443040;
                4:  c = 32'd4293918848;
                5:  c = 32'd4292870656;
                6:  c = 32'd4290775039;
                7:  c = 32'd4286586875;
                8:  c = 32'd4278222805;
                9:  c = 32'd4261543595;
                10: c = 32'd4228380000;
                11: c = 32'd4162825044;
                12: c = 32'd4034748382;
                13: c = 32'd3790295335;
                14: c = 32'd3344923893;
                15: c = 32'd2605029347;
                16: c = 32'd1580030169;
                17: c = 32'd581260614;
                18: c = 32'd78665070;
                19: c = 32'd1440801;
                20: c = 32'd483;
                default: c = 32'd0;
            endcase
            return c;
        end
    endfunction

endpackage

FILE: rtl/core/gkde_ram.sv
module gkde_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/gkde_lane.sv
module gkde_lane (
    input  logic                              i_clk,
    input  gkde_pkg::t_lane_ctl               i_ctl,
    input  logic signed [gkde_pkg::COORD_W-1:0] i_coord,
    input  logic [gkde_pkg::IBW_W-1:0]        i_inv_bw,
    input  logic signed [gkde_pkg::COORD_W-1:0] i_query,
    input  logic signed [gkde_pkg::COORD_W-1:0] i_point,
    output logic signed [gkde_pkg::COORD_W-1:0] o_scaled,
    output logic [gkde_pkg::SQ_W-1:0]         o_sq
);

    logic signed [32:0] w_prod;
    logic signed [32:0] r_prod;
    logic signed [33:0] w_bias;
    logic signed [33:0] w_rnd;
    logic signed [16:0] w_diff;
    logic signed [33:0] w_sq;
    logic [gkde_pkg::SQ_W-1:0] r_sq;

    // scale coordinate by reciprocal bandwidth, exact in Q.20
    assign w_prod = $signed({{17{i_coord[15]}}, i_coord}) * $signed({17'd0, i_inv_bw});

    always_ff @(posedge i_clk) begin
        if (i_ctl.scale_en) begin
            r_prod <= w_prod;
        end
    end

    // round to Q8.8, ties toward plus infinity, then saturate
    assign w_bias = $signed({r_prod[32], r_prod}) + 34'sd2048;
    assign w_rnd  = w_bias >>> 12;

    always_comb begin
        if (w_rnd > 34'sd32767) begin
            o_scaled = 16'sh7FFF;
        end else if (w_rnd < -34'sd32768) begin
            o_scaled = 16'sh8000;
        end else begin
            o_scaled = w_rnd[15:0];
        end
    end

    // squared difference, dropped for unused dimensions
    assign w_diff = $signed({i_query[15], i_query}) - $signed({i_point[15], i_point});
    assign w_sq   = $signed({{17{w_diff[16]}}, w_diff}) * $signed({{17{w_diff[16]}}, w_diff});

    always_ff @(posedge i_clk) begin
        r_sq <= i_ctl.dim_used ? w_sq[gkde_pkg::SQ_W-1:0] : '0;
    end

    assign o_sq = r_sq;

endmodule

FILE: rtl/core/gkde_kernel.sv
module gkde_kernel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [gkde_pkg::KBITS-1:0]    i_t,
    input  logic                          i_far,
    output logic                          o_valid,
    output logic [gkde_pkg::K_W-1:0]      o_k
);

    localparam int KB = gkde_pkg::KBITS;
    localparam int KW = gkde_pkg::K_W;

    logic [KW-1:0] w_k    [KB+1];
    logic [KB-1:0] w_t    [KB+1];
    logic          w_v    [KB+1];
    logic [KW-1:0] r_k    [KB];
    logic [KB-1:0] r_t    [KB];
    logic          r_v    [KB];

    // start at one, or at zero when the half distance reaches 32
    assign w_k[0] = i_far ? '0 : {1'b1, 32'd0};
    assign w_t[0] = i_t;
    assign w_v[0] = i_valid;

    // one stage per bit of the half distance
    for (genvar b = 0; b < KB; b++) begin : g_stage
        logic [KW+31:0] w_mul;
        logic [KW+31:0] w_rnd;

        assign w_mul = 65'(w_k[b]) * 65'(gkde_pkg::exp_bit(b));
        assign w_rnd = w_mul + 65'(33'h080000000);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[b] <= 1'b0;
            end else begin
                r_v[b] <= w_v[b];
            end
            r_t[b] <= w_t[b];
            r_k[b] <= w_t[b][b] ? w_rnd[KW+31:32] : w_k[b];
        end

        assign w_k[b+1] = r_k[b];
        assign w_t[b+1] = r_t[b];
        assign w_v[b+1] = r_v[b];
    end

    assign o_valid = w_v[KB];
    assign o_k     = w_k[KB];

endmodule

FILE: rtl/core/gaussian_kde_evaluator.sv
// Gaussian product-kernel density estimator.
// Requests: raise start with i_func and i_coord_0..3 while busy is low; the
// request is taken at that edge. Clear (func 0) empties the store and busy
// stays low. Load (func 1) scales the point by the reciprocal bandwidths and
// stores it unless the store is full. Query (func 2) walks every stored
// point, one per cycle through the MAX_DIMS distance lanes and the 21-stage
// exp pipeline, and on an empty store goes straight to the result. Func 3 is
// ignored.
// Result: o_valid is high for one cycle with o_density and o_empty_store;
// the receiver cannot stall and must take it then.
// Configuration: i_cfg_valid with i_cfg_index and i_cfg_data, always ready;
// write only while busy is low. Unknown indexes are dropped.
// Reset (synchronous, active low) empties the store and loads the register
// defaults; the point memory itself is not cleared, only the count.
// Throughput is set by the single read port of the point memory: one point
// per cycle per query.
module gaussian_kde_evaluator #(
    parameter int MAX_POINTS = gkde_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIMS   = gkde_pkg::MAX_DIMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic signed [15:0] i_coord_0,
    input  logic signed [15:0] i_coord_1,
    input  logic signed [15:0] i_coord_2,
    input  logic signed [15:0] i_coord_3,
    output logic        o_valid,
    output logic [31:0] o_density,
    output logic        o_empty_store,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [gkde_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gkde_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int PW    = gkde_pkg::COORD_W * MAX_DIMS;
    localparam int D2_W  = gkde_pkg::SQ_W + $clog2(MAX_DIMS);
    localparam int ACC_W = gkde_pkg::K_W + CW;
    localparam int HI_W  = ACC_W - 32;
    localparam int SUM_W = 66;

    gkde_pkg::t_state r_state, n_state;

    logic [2:0]  r_dims;
    logic [15:0] r_ibw [gkde_pkg::NUM_BW];
    logic [31:0] r_norm;

    logic [1:0]  r_func;
    logic signed [15:0] r_coord [gkde_pkg::NUM_BW];
    logic signed [15:0] w_coord [gkde_pkg::NUM_BW];

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_addr;
    logic [CW-1:0] r_seen;
    logic [PW-1:0] r_query;
    logic [PW-1:0] w_scaled;
    logic [PW-1:0] w_rdata;

    logic          r_v1, r_v2, r_v3;
    logic [D2_W-1:0] w_d2;
    logic [D2_W-1:0] r_d2;
    logic [gkde_pkg::SQ_W-1:0] w_sq [MAX_DIMS];
    logic [2:0]    w_nd;

    logic          w_kv;
    logic [gkde_pkg::K_W-1:0] w_k;
    logic [ACC_W-1:0] r_acc;
    logic [63:0]   r_ma;
    logic [HI_W+31:0] r_mb;
    logic [SUM_W-1:0] w_sum;
    logic [31:0]   r_dens;
    logic          r_empty;

    logic          w_accept;
    logic          w_scale_en;
    logic          w_round;
    logic          w_walk;
    logic          w_we;

    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign w_coord[0] = i_coord_0;
    assign w_coord[1] = i_coord_1;
    assign w_coord[2] = i_coord_2;
    assign w_coord[3] = i_coord_3;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= 3'd1;
            for (int i = 0; i < gkde_pkg::NUM_BW; i++) begin
                r_ibw[i] <= 16'd4096;
            end
            r_norm <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (gkde_pkg::t_cfg_idx'(i_cfg_index))
                gkde_pkg::CFG_DIMS: r_dims   <= i_cfg_data[2:0];
                gkde_pkg::CFG_IBW0: r_ibw[0] <= i_cfg_data[15:0];
                gkde_pkg::CFG_IBW1: r_ibw[1] <= i_cfg_data[15:0];
                gkde_pkg::CFG_IBW2: r_ibw[2] <= i_cfg_data[15:0];
                gkde_pkg::CFG_IBW3: r_ibw[3] <= i_cfg_data[15:0];
                gkde_pkg::CFG_NORM: r_norm   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective dimension count
    always_comb begin
        if (r_dims == 3'd0) begin
            w_nd = 3'd1;
        end else if (r_dims > 3'(MAX_DIMS)) begin
            w_nd = 3'(MAX_DIMS);
        end else begin
            w_nd = r_dims;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gkde_pkg::S_IDLE: begin
                if (w_accept && (i_func == gkde_pkg::FN_LOAD ||
                                 i_func == gkde_pkg::FN_QUERY)) begin
                    n_state = gkde_pkg::S_SCALE;
                end
            end
            gkde_pkg::S_SCALE: n_state = gkde_pkg::S_ROUND;
            gkde_pkg::S_ROUND: begin
                if (r_func != gkde_pkg::FN_QUERY) begin
                    n_state = gkde_pkg::S_IDLE;
                end else if (r_count == '0) begin
                    n_state = gkde_pkg::S_OUT;
                end else begin
                    n_state = gkde_pkg::S_WALK;
                end
            end
            gkde_pkg::S_WALK: begin
                if (r_addr == r_count - CW'(1)) begin
                    n_state = gkde_pkg::S_DRAIN;
                end
            end
            gkde_pkg::S_DRAIN: begin
                if (r_seen == r_count) begin
                    n_state = gkde_pkg::S_MUL;
                end
            end
            gkde_pkg::S_MUL:  n_state = gkde_pkg::S_ADD;
            gkde_pkg::S_ADD:  n_state = gkde_pkg::S_OUT;
            gkde_pkg::S_OUT:  n_state = gkde_pkg::S_IDLE;
            default:          n_state = gkde_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy       = 1'b1;
        o_valid    = 1'b0;
        w_scale_en = 1'b0;
        w_round    = 1'b0;
        w_walk     = 1'b0;
        case (r_state)
            gkde_pkg::S_IDLE:  busy = 1'b0;
            gkde_pkg::S_SCALE: w_scale_en = 1'b1;
            gkde_pkg::S_ROUND: w_round = 1'b1;
            gkde_pkg::S_WALK:  w_walk = 1'b1;
            gkde_pkg::S_OUT:   o_valid = 1'b1;
            default: ;
        endcase
    end

    assign w_we = w_round && (r_func == gkde_pkg::FN_LOAD) &&
                  (r_count < CW'(MAX_POINTS));

    // state register, point count, walk address and kernel count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gkde_pkg::S_IDLE;
            r_count <= '0;
            r_addr  <= '0;
            r_seen  <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_walk;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            if (w_accept && i_func == gkde_pkg::FN_CLEAR) begin
                r_count <= '0;
            end else if (w_we) begin
                r_count <= r_count + CW'(1);
            end
            if (w_round) begin
                r_addr <= '0;
                r_seen <= '0;
            end else begin
                if (w_walk) begin
                    r_addr <= r_addr + CW'(1);
                end
                if (w_kv) begin
                    r_seen <= r_seen + CW'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_func;
            for (int i = 0; i < gkde_pkg::NUM_BW; i++) begin
                r_coord[i] <= w_coord[i];
            end
        end
        if (w_round) begin
            r_query <= w_scaled;
            r_acc   <= '0;
            r_dens  <= '0;
            r_empty <= (r_count == '0);
        end else if (w_kv) begin
            r_acc <= r_acc + ACC_W'(w_k);
        end
        r_d2 <= w_d2;
        if (r_state == gkde_pkg::S_MUL) begin
            r_ma <= 64'(r_acc[31:0]) * 64'(r_norm);
            r_mb <= (HI_W+32)'(r_acc[ACC_W-1:32]) * (HI_W+32)'(r_norm);
        end
        if (r_state == gkde_pkg::S_ADD) begin
            r_dens <= (|w_sum[SUM_W-1:48]) ? 32'hFFFF_FFFF : w_sum[47:16];
        end
    end

    assign w_sum = SUM_W'(r_mb) + SUM_W'(r_ma[63:32]);

    gkde_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_scaled),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // one lane per dimension
    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
        gkde_pkg::t_lane_ctl w_ctl;
        logic signed [15:0] w_lane_scaled;

        assign w_ctl.scale_en = w_scale_en;
        assign w_ctl.dim_used = (3'(d) < w_nd);

        gkde_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_coord  (r_coord[d]),
            .i_inv_bw (r_ibw[d]),
            .i_query  (r_query[16*d +: 16]),
            .i_point  (w_rdata[16*d +: 16]),
            .o_scaled (w_lane_scaled),
            .o_sq     (w_sq[d])
        );

        assign w_scaled[16*d +: 16] = w_lane_scaled;
    end

    // merge lanes into the squared distance
    always_comb begin
        w_d2 = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            w_d2 = w_d2 + D2_W'(w_sq[d]);
        end
    end

    gkde_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_t     (r_d2[gkde_pkg::KBITS:1]),
        .i_far   (|r_d2[D2_W-1:gkde_pkg::KBITS+1]),
        .o_valid (w_kv),
        .o_k     (w_k)
    );

    assign o_density     = r_dens;
    assign o_empty_store = r_empty;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count above capacity");
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_kv |-> (r_seen < r_count))
        else $error("more kernels than stored points");
    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == gkde_pkg::FN_QUERY) |=> busy)
        else $error("query taken without going busy");
`endif

endmodule
